// ===== rtl/core/fbfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_pkg
// types and constants shared by the block free list modules
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;

    localparam logic [CNT_W-1:0] END_MARK = CNT_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [CNT_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] free_count;
        t_status          status;
    } t_result;

    function automatic logic [CNT_W-1:0] clamp_pool(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (n == '0) begin
            r = CNT_W'(1);
        end else if (n > END_MARK) begin
            r = END_MARK;
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fbfl_link_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_link_mem
// link memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module fbfl_link_mem
    import fbfl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_mem_req         i_req,
    output logic      [CNT_W-1:0] o_rdata
);

    logic [CNT_W-1:0] mem [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fbfl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_ctrl
// command sequencer: head pointer, free counter and link memory sweep
// ----------------------------------------------------------------------------
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_cmd             i_cmd,
    input  wire logic [IDX_W-1:0] i_fidx,
    input  wire logic [CNT_W-1:0] i_num_blocks,
    input  wire logic             i_slot_free,
    output logic                  o_res_valid,
    output t_result               o_res,
    output t_mem_req              o_mem_req,
    input  wire logic [CNT_W-1:0] i_mem_rdata
);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0] r_fidx, n_fidx;
    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_pool, n_pool;
    logic [IDX_W-1:0] r_sweep, n_sweep;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] sweep_next;

    assign sweep_next = {1'b0, r_sweep} + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_head  <= '0;
            r_cnt   <= END_MARK;
            r_pool  <= END_MARK;
            r_sweep <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_pool  <= n_pool;
            r_sweep <= n_sweep;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_fidx <= n_fidx;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_fidx      = r_fidx;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_pool      = r_pool;
        n_sweep     = r_sweep;
        n_pend      = r_pend;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_mem_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_mem_req.raddr = r_head[IDX_W-1:0];
                if (i_in_valid) begin
                    n_cmd        = i_cmd;
                    n_fidx       = i_fidx;
                    o_mem_req.re = (i_cmd == CMD_ALLOC);
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_INIT) begin
                    n_pool  = clamp_pool(i_num_blocks);
                    n_cnt   = clamp_pool(i_num_blocks);
                    n_sweep = '0;
                    n_pend  = 1'b1;
                    n_state = S_SWEEP;
                end else if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_cmd)
                        CMD_ALLOC: begin
                            if (r_cnt == '0 || r_head >= r_pool) begin
                                o_res.status = ST_EMPTY;
                            end else begin
                                o_res.granted     = 1'b1;
                                o_res.block_index = r_head[IDX_W-1:0];
                                n_head            = i_mem_rdata;
                                n_cnt             = r_cnt - CNT_W'(1);
                            end
                        end
                        CMD_FREE: begin
                            if ({1'b0, r_fidx} >= r_pool) begin
                                o_res.status = ST_RANGE;
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_fidx;
                                o_mem_req.wdata = r_head;
                                n_head          = {1'b0, r_fidx};
                                if (r_cnt < r_pool) begin
                                    n_cnt = r_cnt + CNT_W'(1);
                                end
                            end
                        end
                        CMD_INIT, CMD_NOP: begin
                            o_res.status = ST_OK;
                        end
                        default: begin
                            o_res.status = ST_OK;
                        end
                    endcase
                    o_res.free_count = n_cnt;
                end
            end
            S_SWEEP: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_sweep;
                o_mem_req.wdata = (sweep_next < r_pool) ? sweep_next : END_MARK;
                n_sweep         = r_sweep + IDX_W'(1);
                if (r_sweep == LAST_IDX) begin
                    n_head  = '0;
                    n_cnt   = r_pool;
                    n_state = r_pend ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_res_valid      = 1'b1;
                    o_res.free_count = r_cnt;
                    o_res.status     = ST_OK;
                    n_pend           = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_le_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_pool)
        else $error("free count above pool size");

    a_pool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool != '0 && r_pool <= END_MARK)
        else $error("pool size out of range");

    a_res_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_slot_free)
        else $error("result produced while output slot occupied");

    a_grant_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.granted) |=> r_cnt == $past(r_cnt) - CNT_W'(1))
        else $error("grant did not decrement free count");

    a_no_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_in_ready && !o_res_valid)
        else $error("activity during link memory sweep");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/fixed_block_free_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_free_list
// fixed size block allocator kept as a linked free list in a link memory
//
//   channel   direction  tdata / data                            tuser
//   s_axis    in         [9:0] free_index                        [1:0] cmd
//   m_axis    out        [0] granted [10:1] block_index          [1:0] status
//                        [21:11] free_count
//   cfg       in         [10:0] num_blocks                       -
//
// alloc, free and no-op are accepted in idle, then the exec state takes the link memory
// read result and updates the head. init sweeps all 1024 link entries.
// after reset the same sweep runs before the first transfer.
// a waiting result in the output register holds the sequencer, not the input.
// ----------------------------------------------------------------------------
module fixed_block_free_list
    import fbfl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [9:0] free_index
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [0] granted, [10:1] block_index, [21:11] free_count
    output logic      [1:0]  m_axis_tuser,   // [1:0] status
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data
);

    logic [CNT_W-1:0] r_num_blocks;
    logic             r_out_valid;
    t_result          r_out;
    logic             slot_free;
    logic             res_valid;
    t_result          res;
    t_mem_req         mem_req;
    logic [CNT_W-1:0] mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign slot_free   = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks <= END_MARK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_blocks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    fbfl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_cmd        (t_cmd'(s_axis_tuser)),
        .i_fidx       (s_axis_tdata[IDX_W-1:0]),
        .i_num_blocks (r_num_blocks),
        .i_slot_free  (slot_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    fbfl_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.free_count, r_out.block_index, r_out.granted};
    assign m_axis_tuser  = r_out.status;

endmodule
`default_nettype wire
